FILE: rtl/core/lpfm_pkg.sv
// ----------------------------------------------------------------------------
// LRU page frame manager package
// Shared widths, bit positions and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lpfm_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = 7;
    localparam int FILE_W     = 8;
    localparam int PAGE_W     = 12;
    localparam int STAMP_W    = 64;
    localparam int ENTRY_W    = STAMP_W + FILE_W + PAGE_W;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(NUM_FRAMES);

    // s_tdata: file_id, page_index
    localparam int S_DATA_W = 24;

    // m_tdata: frame, hit, evicted, evicted_file, evicted_page, writeback
    localparam int M_DATA_W    = 32;
    localparam int OUT_HIT_BIT = FRAME_W;
    localparam int OUT_EVC_BIT = FRAME_W + 1;
    localparam int OUT_WB_BIT  = FRAME_W + 2 + FILE_W + PAGE_W;

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } lpfm_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } lpfm_sts_t;

endpackage

FILE: rtl/core/lpfm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/lpfm_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page frame manager controller
// Sequences accept, frame table scan, drain of the last read and commit.
// ----------------------------------------------------------------------------
module lpfm_ctrl import lpfm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lpfm_sts_t sts,
    output lpfm_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.commit = !sts.out_busy;
                if (!sts.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/lpfm_dp.sv
// ----------------------------------------------------------------------------
// LRU page frame manager datapath
// Frame table RAM, used/dirty flags, scan trackers, stamp counter, result
// register.
// ----------------------------------------------------------------------------
module lpfm_dp import lpfm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  lpfm_cmd_t           cmd,
    output lpfm_sts_t           sts,
    input  logic                s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tready
);

    logic [CNT_W-1:0]      count_reg;
    logic                  op_reg;
    logic [FILE_W-1:0]     file_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [FRAME_W-1:0]    idx_reg;
    logic                  rd_vld_reg;
    logic [FRAME_W-1:0]    rd_idx_reg;
    logic                  hit_fnd_reg, hit_fnd_next;
    logic [FRAME_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                  free_fnd_reg, free_fnd_next;
    logic [FRAME_W-1:0]    free_idx_reg, free_idx_next;
    logic                  old_fnd_reg, old_fnd_next;
    logic [FRAME_W-1:0]    old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0]    old_stamp_reg, old_stamp_next;
    logic [FILE_W-1:0]     old_file_reg, old_file_next;
    logic [PAGE_W-1:0]     old_page_reg, old_page_next;
    logic [STAMP_W-1:0]    stamp_reg, stamp_next;
    logic [NUM_FRAMES-1:0] used_reg, used_next;
    logic [NUM_FRAMES-1:0] dirty_reg, dirty_next;
    logic                  out_vld_reg, out_vld_next;
    logic [M_DATA_W-1:0]   out_data_reg, out_data_next;

    logic [FRAME_W-1:0]    last_idx;
    logic [CNT_W-1:0]      cnt_m1;
    logic [ENTRY_W-1:0]    rd_data;
    logic [ENTRY_W-1:0]    wr_data;
    logic [STAMP_W-1:0]    e_stamp;
    logic [FILE_W-1:0]     e_file;
    logic [PAGE_W-1:0]     e_page;
    logic                  e_used;
    logic [FRAME_W-1:0]    slot;
    logic                  evicted;
    logic                  wb;
    logic [FILE_W-1:0]     ev_file;
    logic [PAGE_W-1:0]     ev_page;

    // effective count: 0 acts as 1, above NUM_FRAMES clamps
    assign cnt_m1 = count_reg - CNT_W'(1);
    always_comb begin
        if (count_reg == '0) begin
            last_idx = '0;
        end else if (count_reg > CNT_W'(NUM_FRAMES)) begin
            last_idx = FRAME_W'(NUM_FRAMES - 1);
        end else begin
            last_idx = cnt_m1[FRAME_W-1:0];
        end
    end

    assign sts.scan_last = (idx_reg == last_idx);
    assign sts.out_busy  = out_vld_reg && !m_tready;

    lpfm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_FRAMES)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (slot),
        .wdata (wr_data),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign e_page = rd_data[PAGE_W-1:0];
    assign e_file = rd_data[PAGE_W +: FILE_W];
    assign e_stamp = rd_data[PAGE_W+FILE_W +: STAMP_W];
    assign e_used = used_reg[rd_idx_reg];

    // scan trackers: first hit, first free, oldest stamp
    always_comb begin
        hit_fnd_next   = hit_fnd_reg;
        hit_idx_next   = hit_idx_reg;
        free_fnd_next  = free_fnd_reg;
        free_idx_next  = free_idx_reg;
        old_fnd_next   = old_fnd_reg;
        old_idx_next   = old_idx_reg;
        old_stamp_next = old_stamp_reg;
        old_file_next  = old_file_reg;
        old_page_next  = old_page_reg;
        if (cmd.start) begin
            hit_fnd_next  = 1'b0;
            free_fnd_next = 1'b0;
            old_fnd_next  = 1'b0;
        end else if (rd_vld_reg) begin
            if (!hit_fnd_reg && e_used && e_file == file_reg && e_page == page_reg) begin
                hit_fnd_next = 1'b1;
                hit_idx_next = rd_idx_reg;
            end
            if (!free_fnd_reg && !e_used) begin
                free_fnd_next = 1'b1;
                free_idx_next = rd_idx_reg;
            end
            if (!old_fnd_reg || e_stamp < old_stamp_reg) begin
                old_fnd_next   = 1'b1;
                old_idx_next   = rd_idx_reg;
                old_stamp_next = e_stamp;
                old_file_next  = e_file;
                old_page_next  = e_page;
            end
        end
    end

    // commit
    always_comb begin
        if (hit_fnd_reg) begin
            slot = hit_idx_reg;
        end else if (free_fnd_reg) begin
            slot = free_idx_reg;
        end else begin
            slot = old_idx_reg;
        end
        evicted    = !hit_fnd_reg && !free_fnd_reg;
        wb         = evicted && dirty_reg[old_idx_reg];
        ev_file    = evicted ? old_file_reg : '0;
        ev_page    = evicted ? old_page_reg : '0;
        stamp_next = stamp_reg;
        used_next  = used_reg;
        dirty_next = dirty_reg;
        if (cmd.commit) begin
            stamp_next       = stamp_reg + STAMP_W'(1);
            used_next[slot]  = 1'b1;
            dirty_next[slot] = op_reg || (hit_fnd_reg && dirty_reg[slot]);
        end
        wr_data = {stamp_next, file_reg, page_reg};

        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;
        if (cmd.commit) begin
            out_vld_next  = 1'b1;
            out_data_next = M_DATA_W'({wb, ev_page, ev_file, evicted, hit_fnd_reg, slot});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= CNT_RESET;
            rd_vld_reg    <= 1'b0;
            hit_fnd_reg   <= 1'b0;
            free_fnd_reg  <= 1'b0;
            old_fnd_reg   <= 1'b0;
            stamp_reg     <= '0;
            used_reg      <= '0;
            dirty_reg     <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            rd_vld_reg    <= cmd.issue;
            hit_fnd_reg   <= hit_fnd_next;
            free_fnd_reg  <= free_fnd_next;
            old_fnd_reg   <= old_fnd_next;
            stamp_reg     <= stamp_next;
            used_reg      <= used_next;
            dirty_reg     <= dirty_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= s_tuser;
            file_reg <= s_tdata[FILE_W-1:0];
            page_reg <= s_tdata[FILE_W +: PAGE_W];
            idx_reg  <= '0;
        end else if (cmd.issue) begin
            idx_reg  <= idx_reg + FRAME_W'(1);
        end
        rd_idx_reg    <= idx_reg;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
        old_stamp_reg <= old_stamp_next;
        old_file_reg  <= old_file_next;
        old_page_reg  <= old_page_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/lru_page_frame_manager_unit.sv
// ----------------------------------------------------------------------------
// LRU page frame manager
// Page frame table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Input stream: one transfer per access; s_tuser is the access kind (read or
// write), s_tdata carries file id and page index. Output stream: one transfer
// per access with the frame, hit/evict flags, evicted page and writeback flag.
// cfg_we/cfg_wdata set the number of active frames (0 acts as 1, above 64
// acts as 64); write it only while the block is idle.
// An access goes through a scan of the frame table RAM, one entry per cycle
// over the n active frames, then a drain step and a commit step. The result
// is registered at commit, and the block is then idle and ready for the next
// access. One access is in flight at a time.
// Reset empties every frame, clears dirty flags and the use stamp, and sets
// the frame count to 64; the block is ready straight after reset.
// If the receiver stalls, the result is held in the output register and the
// block takes and scans the next access, then waits before committing it.
// ----------------------------------------------------------------------------
module lru_page_frame_manager_unit import lpfm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,   // op
    input  logic [S_DATA_W-1:0] s_tdata,   // file_id, page_index
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // frame, hit, evicted, evicted_file,
                                           // evicted_page, writeback
);

    lpfm_cmd_t cmd;
    lpfm_sts_t sts;

    lpfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpfm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tready  (m_tready)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("access taken while another in flight");

    a_hit_not_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OUT_HIT_BIT] && m_tdata[OUT_EVC_BIT]))
        else $error("hit and eviction reported together");

    a_wb_needs_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_WB_BIT] |-> m_tdata[OUT_EVC_BIT])
        else $error("writeback without eviction");

    a_commit_on_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("result committed over a stalled transfer");
`endif

endmodule
